// ----- src/lfsp_pkg.sv -----
// Shared types and constants for the LED frame stream parser.
// No dependencies; used by every module of the block.
`default_nettype none

package lfsp_pkg;

  // Saturation limits for the configured group sizes
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_STRIPS   = 8;
  localparam int MAX_LEDS     = 255;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_COUNT    = 2'd0;
  localparam logic [1:0] CFG_STRIP_COUNT      = 2'd1;
  localparam logic [1:0] CFG_STRIP_LED_COUNTS = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_HEADER    = 2'd0;
  localparam logic [1:0] KIND_CHANNEL   = 2'd1;
  localparam logic [1:0] KIND_STRIP     = 2'd2;
  localparam logic [1:0] KIND_FRAME_END = 2'd3;

  // Result queue between parser and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  strip_index;
    logic [7:0]  pixel_index;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  blue;
    logic [31:0] frame_time;
    logic        fade;
    logic        checksum_ok;
  } result_t;

endpackage

`default_nettype wire

// ----- src/lfsp_front.sv -----
// Parser front end: configuration registers, frame state machine, byte sum.
// Depends on lfsp_pkg. Produces at most one result per accepted byte.
`default_nettype none

module lfsp_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 byte_take,
  input  wire logic [7:0]           byte_data,
  output logic                      res_valid,
  output lfsp_pkg::result_t         res
);

  localparam logic [2:0] PH_TIME  = 3'd0;
  localparam logic [2:0] PH_FADE  = 3'd1;
  localparam logic [2:0] PH_CHAN  = 3'd2;
  localparam logic [2:0] PH_STRIP = 3'd3;
  localparam logic [2:0] PH_CSUM  = 3'd4;

  logic [4:0]  chan_cnt_r;
  logic [3:0]  strip_cnt_r;
  logic [63:0] led_cnts_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  bp_r, bp_nxt;
  logic [7:0]  item_r, item_nxt;
  logic [3:0]  strip_r, strip_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [7:0]  red_r, red_nxt;
  logic [31:0] time_r, time_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [23:0] csum_r, csum_nxt;

  // state after skipping completed groups
  logic [2:0]  ph_s;
  logic [1:0]  bp_s;
  logic [7:0]  item_s;
  logic [3:0]  strip_s;

  logic [7:0]  eff_ch;
  logic [3:0]  eff_st;
  logic [7:0]  leds [lfsp_pkg::MAX_STRIPS];
  logic        found;
  logic [3:0]  found_s;
  logic [31:0] stored;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r  <= '0;
      strip_cnt_r <= '0;
      led_cnts_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lfsp_pkg::CFG_CHANNEL_COUNT:    chan_cnt_r  <= cfg_data[4:0];
        lfsp_pkg::CFG_STRIP_COUNT:      strip_cnt_r <= cfg_data[3:0];
        lfsp_pkg::CFG_STRIP_LED_COUNTS: led_cnts_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective group sizes
  always_comb begin
    eff_ch = (8'(chan_cnt_r) > 8'(lfsp_pkg::MAX_CHANNELS)) ?
             8'(lfsp_pkg::MAX_CHANNELS) : 8'(chan_cnt_r);
    eff_st = (strip_cnt_r > 4'(lfsp_pkg::MAX_STRIPS)) ?
             4'(lfsp_pkg::MAX_STRIPS) : strip_cnt_r;
    for (int i = 0; i < lfsp_pkg::MAX_STRIPS; i++) begin
      leds[i] = (led_cnts_r[i*8 +: 8] > 8'(lfsp_pkg::MAX_LEDS)) ?
                8'(lfsp_pkg::MAX_LEDS) : led_cnts_r[i*8 +: 8];
    end
  end

  // skip groups that are already complete under the live config
  always_comb begin
    ph_s    = phase_r;
    bp_s    = bp_r;
    item_s  = item_r;
    strip_s = strip_r;
    found   = 1'b0;
    found_s = '0;
    if (phase_r == PH_CHAN && item_r >= eff_ch) begin
      ph_s    = PH_STRIP;
      strip_s = '0;
      item_s  = '0;
      bp_s    = '0;
    end
    if (ph_s == PH_STRIP) begin
      // lowest strip at or after the current one that still has LEDs to go
      for (int i = lfsp_pkg::MAX_STRIPS - 1; i >= 0; i--) begin
        if (4'(i) >= strip_s && 4'(i) < eff_st) begin
          if ((4'(i) == strip_s) ? (item_s < leds[i]) : (leds[i] != 8'd0)) begin
            found   = 1'b1;
            found_s = 4'(i);
          end
        end
      end
      if (!found) begin
        ph_s   = PH_CSUM;
        bp_s   = '0;
        item_s = '0;
      end else if (found_s != strip_s) begin
        strip_s = found_s;
        item_s  = '0;
        bp_s    = '0;
      end
    end
  end

  always_comb begin
    phase_nxt = ph_s;
    bp_nxt    = bp_s;
    item_nxt  = item_s;
    strip_nxt = strip_s;
    green_nxt = green_r;
    red_nxt   = red_r;
    time_nxt  = time_r;
    sum_nxt   = sum_r;
    csum_nxt  = csum_r;
    res_valid = 1'b0;
    res       = '0;
    stored    = {byte_data, csum_r};
    case (ph_s)
      PH_TIME: begin
        if (bp_s == 2'd0) begin
          sum_nxt  = 32'(byte_data);
          time_nxt = 32'(byte_data);
        end else begin
          sum_nxt  = sum_r + 32'(byte_data);
          time_nxt = time_r | (32'(byte_data) << {bp_s, 3'b000});
        end
        if (bp_s == 2'd3) begin
          bp_nxt    = '0;
          phase_nxt = PH_FADE;
        end else begin
          bp_nxt = bp_s + 2'd1;
        end
      end
      PH_FADE: begin
        sum_nxt          = sum_r + 32'(byte_data);
        res_valid        = 1'b1;
        res.result_kind  = lfsp_pkg::KIND_HEADER;
        res.frame_time   = time_r;
        res.fade         = (byte_data != 8'd0);
        phase_nxt        = PH_CHAN;
        item_nxt         = '0;
        bp_nxt           = '0;
      end
      PH_CHAN, PH_STRIP: begin
        sum_nxt = sum_r + 32'(byte_data);
        if (bp_s == 2'd0) begin
          green_nxt = byte_data;
          bp_nxt    = 2'd1;
        end else if (bp_s == 2'd1) begin
          red_nxt = byte_data;
          bp_nxt  = 2'd2;
        end else begin
          res_valid       = 1'b1;
          res.result_kind = (ph_s == PH_CHAN) ? lfsp_pkg::KIND_CHANNEL
                                              : lfsp_pkg::KIND_STRIP;
          res.strip_index = (ph_s == PH_CHAN) ? 3'd0 : strip_s[2:0];
          res.pixel_index = item_s;
          res.green       = green_r;
          res.red         = red_r;
          res.blue        = byte_data;
          bp_nxt          = '0;
          item_nxt        = item_s + 8'd1;
        end
      end
      PH_CSUM: begin
        if (bp_s == 2'd3) begin
          res_valid       = 1'b1;
          res.result_kind = lfsp_pkg::KIND_FRAME_END;
          res.checksum_ok = (stored == sum_r);
          phase_nxt       = PH_TIME;
          bp_nxt          = '0;
          item_nxt        = '0;
          strip_nxt       = '0;
          csum_nxt        = '0;
        end else begin
          if (bp_s == 2'd0) begin
            csum_nxt = 24'(byte_data);
          end else begin
            csum_nxt = csum_r | (24'(byte_data) << {bp_s, 3'b000});
          end
          bp_nxt = bp_s + 2'd1;
        end
      end
      default: begin
        phase_nxt = PH_TIME;
        bp_nxt    = '0;
      end
    endcase
    if (!byte_take) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TIME;
      bp_r    <= '0;
      item_r  <= '0;
      strip_r <= '0;
      green_r <= '0;
      red_r   <= '0;
      time_r  <= '0;
      sum_r   <= '0;
      csum_r  <= '0;
    end else if (byte_take) begin
      phase_r <= phase_nxt;
      bp_r    <= bp_nxt;
      item_r  <= item_nxt;
      strip_r <= strip_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
      time_r  <= time_nxt;
      sum_r   <= sum_nxt;
      csum_r  <= csum_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/lfsp_queue.sv -----
// Short result queue that decouples the parser from the output stage.
// Depends on lfsp_pkg for the result type and depth.
`default_nettype none

module lfsp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lfsp_pkg::result_t push_data,
  input  wire logic              pop,
  output logic                   full,
  output logic                   empty,
  output lfsp_pkg::result_t      head
);

  lfsp_pkg::result_t     slots [lfsp_pkg::QDEPTH];
  logic [lfsp_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [lfsp_pkg::QAW:0]   count_r, count_nxt;

  assign full  = (count_r == (lfsp_pkg::QAW+1)'(lfsp_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = slots[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("result queue underflow");

  a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != (lfsp_pkg::QAW+1)'(lfsp_pkg::QDEPTH) && count_r != '0) |->
      (wr_ptr_r - rd_ptr_r) == count_r[lfsp_pkg::QAW-1:0])
    else $error("result queue count out of step with pointers");

endmodule

`default_nettype wire

// ----- src/lfsp_back.sv -----
// Output stage: registered result holding the out channel under stall.
// Depends on lfsp_pkg for the result type.
`default_nettype none

module lfsp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire lfsp_pkg::result_t q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lfsp_pkg::result_t      out_res
);

  logic              valid_r;
  lfsp_pkg::result_t res_r;

  // reload when empty or when the held result transfers this cycle
  assign q_pop     = !q_empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= q_head;
  end

endmodule

`default_nettype wire

// ----- src/led_frame_stream_parser.sv -----
// Top level of the LED frame stream parser: ports, parser, queue, output stage.
// Depends on lfsp_pkg, lfsp_front, lfsp_queue and lfsp_back.
//
// Usage:
//   in_*   : one frame byte per transfer (in_valid high, in_stall low).
//   out_*  : header, channel pixel, strip pixel and frame-end results; a
//            transfer happens when out_valid is high and out_stall is low.
//   cfg_*  : register writes (0 channel_count, 1 strip_count,
//            2 strip_led_counts); cfg_ready is always high, other indexes
//            are ignored. Write only while the block is idle.
// Throughput: one byte per cycle while in_stall is low.
// Path: a result reaches out_* from the parser through the queue and then the
//   output register (parser -> queue -> output register).
// Stall: the output register holds its result while out_stall is high; the
//   four-entry queue absorbs results meanwhile, and in_stall rises only when
//   the queue is full.
// Reset (rst_n low, synchronous): configuration clears to zero, the parser
//   waits for the first start-time byte, queue and output are emptied.
`default_nettype none

module led_frame_stream_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [2:0]       out_strip_index,
  output logic [7:0]       out_pixel_index,
  output logic [7:0]       out_green,
  output logic [7:0]       out_red,
  output logic [7:0]       out_blue,
  output logic [31:0]      out_frame_time,
  output logic             out_fade,
  output logic             out_checksum_ok,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic              q_full, q_empty, q_pop;
  logic              byte_take;
  logic              res_valid;
  lfsp_pkg::result_t res, q_head, out_res;

  // back-pressure only when the queue cannot take another result
  assign in_stall  = q_full;
  assign byte_take = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  lfsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_take (byte_take),
    .byte_data (in_data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  lfsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  lfsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_result_kind = out_res.result_kind;
  assign out_strip_index = out_res.strip_index;
  assign out_pixel_index = out_res.pixel_index;
  assign out_green       = out_res.green;
  assign out_red         = out_res.red;
  assign out_blue        = out_res.blue;
  assign out_frame_time  = out_res.frame_time;
  assign out_fade        = out_res.fade;
  assign out_checksum_ok = out_res.checksum_ok;

endmodule

`default_nettype wire
